FILE: sv/optb_pkg.sv
// Shared types, codes and constants of the one-shot and periodic timer bank.
package optb_pkg;

	// Default number of timer slots.
	localparam int TIMER_SLOTS_DEF = 16;
	// Upper bound on the fired reports that one tick may produce.
	localparam int MAX_RESULTS = 16;
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	localparam logic OP_CREATE   = 1'b0;
	localparam logic OP_TICK     = 1'b1;
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] timeout_seconds;
		logic        periodic;
		logic [31:0] tag;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic        status;
		logic [3:0]  slot;
		logic [31:0] fired_tag;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic        periodic;
		logic [31:0] reload;
		logic [63:0] deadline;
		logic [31:0] tag;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CREATE,
		ST_RD_AGE,
		ST_RD_SLOT,
		ST_EVAL,
		ST_FLUSH
	} state_t;

endpackage

FILE: sv/optb_req_if.sv
// Request channel interface: valid, ready and one request item.
interface optb_req_if import optb_pkg::*;;
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/optb_rsp_if.sv
// Response channel interface: valid, ready and one result item.
interface optb_rsp_if import optb_pkg::*;;
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/oneshot_periodic_timer_bank.sv
// Top level of the one-shot and periodic timer bank.
//
// Usage: requests arrive on the req channel, results leave on the rsp channel;
// both use a valid/ready handshake and a transaction completes on a clock edge
// where valid and ready are both high. A create request stores a timer in the
// lowest free slot with deadline now + timeout and answers with exactly one
// acknowledgement (status full, slot 0, when every slot is taken). A tick
// request advances the seconds counter and then walks the live timers from the
// newest to the oldest, reporting each due timer; a tick with nothing due gives
// no result at all. The last result of a request carries last = 1.
//
// Sequence: the acknowledgement of a create is loaded into the output register
// from the create state, which waits for room there, and the next request is
// accepted once the block is back in idle. A tick with live timers walks them
// one by one: each timer costs an age-list read, a record read that depends
// on it and an evaluate step, then a flush step and the idle state follow.
// A tick on an empty bank stays in idle. Requests are taken one at a time.
//
// Reset clears the counter, the slot valid bits and the live count; the
// storage contents are left as they are. When the receiver stalls, the result
// stays in the output register and the walk pauses on the next due timer.
module oneshot_periodic_timer_bank import optb_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	optb_req_if.sink   req,
	optb_rsp_if.source rsp
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

	// Wrapping step backward and forward through the circular age list.
	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
		return (p == '0) ? LAST_IDX : p - IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + IDX_W'(1);
	endfunction

	state_t state_q, state_d;

	// Control state.
	logic [63:0]            now_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]       live_q;
	logic [IDX_W-1:0]       tail_q;
	logic [IDX_W-1:0]       rp_q;
	logic [IDX_W-1:0]       wp_q;
	logic [CNT_W-1:0]       left_q;
	logic [RES_W-1:0]       n_q;
	logic                   out_valid_q;
	logic                   pend_valid_q;

	// Payload registers.
	req_t             req_q;
	rsp_t             out_q;
	rsp_t             pend_q;
	logic [IDX_W-1:0] s_q;

	// Storage ports.
	logic [IDX_W-1:0] slot_raddr;
	slot_entry_t      slot_rdata;
	logic             slot_we;
	logic [IDX_W-1:0] slot_waddr;
	slot_entry_t      slot_wdata;
	logic [IDX_W-1:0] age_rdata;
	logic             age_we;
	logic [IDX_W-1:0] age_waddr;
	logic [IDX_W-1:0] age_wdata;

	// Sequencer outputs.
	logic             out_free;
	logic             out_load;
	rsp_t             out_d;
	logic             pend_load;
	rsp_t             pend_d;
	logic             pend_clr;
	logic             eval_step;
	logic             create_ok;
	logic             due;
	logic             keep;
	logic             req_accept;
	logic             free_any;
	logic [IDX_W-1:0] free_idx;

	optb_store #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_store (
		.clk        (clk),
		.slot_raddr (slot_raddr),
		.slot_rdata (slot_rdata),
		.slot_we    (slot_we),
		.slot_waddr (slot_waddr),
		.slot_wdata (slot_wdata),
		.age_raddr  (rp_q),
		.age_rdata  (age_rdata),
		.age_we     (age_we),
		.age_waddr  (age_waddr),
		.age_wdata  (age_wdata)
	);

	// Lowest-numbered free slot.
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// The age list read is registered and returns a slot number; the record of
	// that slot is then read and held while the walk evaluates it.
	assign slot_raddr = (state_q == ST_RD_SLOT) ? age_rdata : s_q;

	assign due  = (n_q < RES_W'(MAX_RESULTS)) && (slot_rdata.deadline <= now_q);
	assign keep = !due || slot_rdata.periodic;

	assign out_free   = !out_valid_q || rsp.ready;
	assign req_accept = req.valid && req.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		pend_d.kind      = KIND_FIRED;
		pend_d.status    = STATUS_OK;
		pend_d.slot      = 4'(s_q);
		pend_d.fired_tag = slot_rdata.tag;
		pend_d.last      = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		age_we     = 1'b0;
		age_waddr  = wp_q;
		age_wdata  = s_q;
		slot_we    = 1'b0;
		slot_waddr = s_q;
		slot_wdata = slot_rdata;
		out_load   = 1'b0;
		out_d      = '0;
		pend_load  = 1'b0;
		pend_clr   = 1'b0;
		eval_step  = 1'b0;
		create_ok  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.data.opcode == OP_CREATE) begin
						state_d = ST_CREATE;
					end else if (live_q != '0) begin
						state_d = ST_RD_AGE;
					end
				end
			end
			ST_CREATE: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_d.kind = KIND_ACK;
					out_d.last = 1'b1;
					if (free_any) begin
						create_ok           = 1'b1;
						slot_we             = 1'b1;
						slot_waddr          = free_idx;
						slot_wdata.periodic = req_q.periodic;
						slot_wdata.reload   = req_q.timeout_seconds;
						slot_wdata.deadline = now_q + 64'(req_q.timeout_seconds);
						slot_wdata.tag      = req_q.tag;
						age_we              = 1'b1;
						age_waddr           = tail_q;
						age_wdata           = free_idx;
						out_d.status        = STATUS_OK;
						out_d.slot          = 4'(free_idx);
					end else begin
						out_d.status = STATUS_FULL;
					end
					state_d = ST_IDLE;
				end
			end
			ST_RD_AGE: begin
				state_d = ST_RD_SLOT;
			end
			ST_RD_SLOT: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				// A new due timer pushes the held one out, so it waits for room.
				if (!(due && pend_valid_q && !out_free)) begin
					eval_step = 1'b1;
					if (due) begin
						pend_load = 1'b1;
						if (pend_valid_q) begin
							out_load = 1'b1;
							out_d    = pend_q;
						end
						if (slot_rdata.periodic) begin
							slot_we             = 1'b1;
							slot_wdata.deadline = now_q + 64'(slot_rdata.reload);
						end
					end
					age_we  = keep;
					state_d = (left_q == CNT_W'(1)) ? ST_FLUSH : ST_RD_AGE;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_d      = pend_q;
					out_d.last = 1'b1;
					pend_clr   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers. The walk reads the age list downward at rp and writes
	// the surviving entries back downward at wp, which never falls below rp, so
	// the list stays compact and its tail never moves during a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			valid_q      <= '0;
			live_q       <= '0;
			tail_q       <= '0;
			rp_q         <= '0;
			wp_q         <= '0;
			left_q       <= '0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (req_accept && req.data.opcode == OP_TICK) begin
				now_q  <= now_q + 64'd1;
				rp_q   <= idx_dec(tail_q);
				wp_q   <= idx_dec(tail_q);
				left_q <= live_q;
				n_q    <= '0;
			end
			if (create_ok) begin
				valid_q[free_idx] <= 1'b1;
				live_q            <= live_q + CNT_W'(1);
				tail_q            <= idx_inc(tail_q);
			end
			if (eval_step) begin
				rp_q   <= idx_dec(rp_q);
				left_q <= left_q - CNT_W'(1);
				if (keep) begin
					wp_q <= idx_dec(wp_q);
				end
				if (due) begin
					n_q <= n_q + RES_W'(1);
				end
				if (!keep) begin
					valid_q[s_q] <= 1'b0;
					live_q       <= live_q - CNT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= req.data;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (state_q == ST_RD_SLOT) begin
			s_q <= age_rdata;
		end
	end

	// The live count never exceeds the number of slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(TIMER_SLOTS))
		else $error("live count exceeds the slot count");

	// The live count always matches the number of occupied slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(live_q))
		else $error("live count disagrees with the slot valid bits");

	// A fired report is never left behind when the walk ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held fired report left over after a tick");

	// A create always ends in an acknowledgement marked as the last result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CREATE && out_free) |=> (out_valid_q && out_q.last))
		else $error("create finished without a final acknowledgement");

endmodule

FILE: sv/optb_store.sv
// Timer storage: per-slot timer records and the age-ordered slot list.
module optb_store import optb_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
	input  logic             clk,
	input  logic [IDX_W-1:0] slot_raddr,
	output slot_entry_t      slot_rdata,
	input  logic             slot_we,
	input  logic [IDX_W-1:0] slot_waddr,
	input  slot_entry_t      slot_wdata,
	input  logic [IDX_W-1:0] age_raddr,
	output logic [IDX_W-1:0] age_rdata,
	input  logic             age_we,
	input  logic [IDX_W-1:0] age_waddr,
	input  logic [IDX_W-1:0] age_wdata
);

	slot_entry_t      slot_mem [TIMER_SLOTS];
	logic [IDX_W-1:0] age_mem  [TIMER_SLOTS];

	// Both memories have one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rdata <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (age_we) begin
			age_mem[age_waddr] <= age_wdata;
		end
		age_rdata <= age_mem[age_raddr];
	end

endmodule

FILE: tb/timer_report_checker.sv
// Checker that predicts the timer bank's reports and compares them with the result channel.
module timer_report_checker import optb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	optb_req_if  req,
	optb_rsp_if  rsp,
	output int   error_count,
	output int   pending,
	output int   ack_count,
	output int   full_count,
	output int   fired_count
);

	localparam int SLOTS = TIMER_SLOTS_DEF;

	logic [63:0] now_secs;
	logic        live[SLOTS];
	logic        rearms[SLOTS];
	logic [31:0] reload_secs[SLOTS];
	logic [63:0] due_at[SLOTS];
	logic [31:0] timer_tag[SLOTS];
	int          age_list[SLOTS];
	int          live_n;
	rsp_t        pending_reports[$];
	int          err_n;
	int          ack_n;
	int          full_n;
	int          fired_n;

	// Works out the reports that one request causes and updates the timer state.
	task automatic apply_timer_request(input req_t r);
		int   s;
		int   i;
		int   n;
		rsp_t res;
		rsp_t held;
		logic have_held;
		have_held = 1'b0;
		if (r.opcode == OP_CREATE) begin
			s = 0;
			while (s < SLOTS && live[s])
				s++;
			res = '0;
			res.kind = KIND_ACK;
			res.last = 1'b1;
			if (s >= SLOTS) begin
				res.status = STATUS_FULL;
			end else begin
				live[s] = 1'b1;
				rearms[s] = r.periodic;
				reload_secs[s] = r.timeout_seconds;
				due_at[s] = now_secs + {32'd0, r.timeout_seconds};
				timer_tag[s] = r.tag;
				age_list[live_n] = s;
				live_n++;
				res.status = STATUS_OK;
				res.slot = s[3:0];
			end
			pending_reports.push_back(res);
		end else begin
			now_secs = now_secs + 64'd1;
			n = 0;
			i = live_n;
			while (i > 0 && n < MAX_RESULTS) begin
				i--;
				s = age_list[i];
				if (due_at[s] <= now_secs) begin
					// The previous report is not the final one, so it can go out now.
					if (have_held)
						pending_reports.push_back(held);
					held = '0;
					held.kind = KIND_FIRED;
					held.status = STATUS_OK;
					held.slot = s[3:0];
					held.fired_tag = timer_tag[s];
					have_held = 1'b1;
					n++;
					if (rearms[s]) begin
						due_at[s] = now_secs + {32'd0, reload_secs[s]};
					end else begin
						live[s] = 1'b0;
						for (int j = i; j < live_n - 1; j++)
							age_list[j] = age_list[j + 1];
						live_n--;
					end
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				pending_reports.push_back(held);
			end
		end
	endtask

	task automatic check_report(input rsp_t got);
		rsp_t want;
		if (pending_reports.size() == 0) begin
			$error("unexpected report: kind %0d slot %0d tag 0x%08h",
				got.kind, got.slot, got.fired_tag);
			err_n++;
		end else begin
			want = pending_reports.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				err_n++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				err_n++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, got %0d", want.slot, got.slot);
				err_n++;
			end
			if (got.fired_tag !== want.fired_tag) begin
				$error("fired_tag: expected 0x%08h, got 0x%08h", want.fired_tag, got.fired_tag);
				err_n++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				err_n++;
			end
			if (want.kind == KIND_FIRED)
				fired_n++;
			else if (want.status == STATUS_FULL)
				full_n++;
			else
				ack_n++;
		end
	endtask

	// Both channels are sampled at the clock edge, before the edge's updates land.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_secs = '0;
			live_n = 0;
			for (int k = 0; k < SLOTS; k++)
				live[k] = 1'b0;
			pending_reports.delete();
			err_n = 0;
			ack_n = 0;
			full_n = 0;
			fired_n = 0;
		end else begin
			if (req.valid && req.ready)
				apply_timer_request(req.data);
			if (rsp.valid && rsp.ready)
				check_report(rsp.data);
		end
		error_count <= err_n;
		pending <= pending_reports.size();
		ack_count <= ack_n;
		full_count <= full_n;
		fired_count <= fired_n;
	end

endmodule

FILE: tb/tb_oneshot_periodic_timer_bank.sv
// Testbench top for the timer bank: clock, reset, request stimulus, result stalls and verdict.
module tb_oneshot_periodic_timer_bank;
	import optb_pkg::*;

	// Random requests after the directed opening; about 360 in all.
	localparam int RANDOM_ITEMS = 336;
	// Requests sent before the idle pattern changes.
	localparam int PHASE_LEN = 120;
	// Timers that never leave the bank (periodic, or one-shot with a huge timeout).
	// Reset is never repeated, so these are rationed to keep free slots around.
	localparam int PERMANENT_BUDGET = 12;
	// A tick walks at most 16 timers, one after another; this covers it with margin.
	localparam int SETTLE_CYCLES = 100;
	localparam int LIMIT_CYCLES = 600000;

	logic clk = 1'b0;
	logic arst_n;

	optb_req_if req_ch ();
	optb_rsp_if rsp_ch ();

	int error_count;
	int pending;
	int ack_count;
	int full_count;
	int fired_count;

	int send_idle;
	int recv_idle;
	int sent_n;
	int tick_n;
	int permanent_made;
	int cycle_count = 0;

	always #2 clk = ~clk;

	oneshot_periodic_timer_bank u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	timer_report_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.error_count (error_count),
		.pending     (pending),
		.ack_count   (ack_count),
		.full_count  (full_count),
		.fired_count (fired_count)
	);

	// The receiver drops ready at random, independent of whether a result is waiting.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// Watchdog: a hung block ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Run stopped at the cycle limit with %0d reports outstanding.", pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic req_t create_req(input logic [31:0] timeout, input logic periodic,
		input logic [31:0] tag);
		req_t r;
		r.opcode = OP_CREATE;
		r.timeout_seconds = timeout;
		r.periodic = periodic;
		r.tag = tag;
		return r;
	endfunction

	// A tick ignores the other fields, so they carry random noise.
	function automatic req_t tick_req();
		req_t r;
		r.opcode = OP_TICK;
		r.timeout_seconds = $urandom;
		r.periodic = 1'($urandom_range(0, 1));
		r.tag = $urandom;
		return r;
	endfunction

	// Stops sending until every predicted report has been taken, then lets the
	// block finish any walk that produced nothing. The checker's pending count is
	// registered, so the task lets it update before it is trusted.
	task automatic drain(input int settle);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Sends one request. Idle cycles come first, then valid is held with the
	// payload until the edge at which ready is seen high; that edge completes the
	// transaction and the task returns in the same time step.
	task automatic send_request(input req_t item);
		// The idle pattern flips at fixed points, each time after a full drain.
		if (sent_n == PHASE_LEN) begin
			drain(SETTLE_CYCLES);
			send_idle = 85;
			recv_idle = 9;
		end else if (sent_n == 2 * PHASE_LEN) begin
			drain(SETTLE_CYCLES);
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent_n++;
		if (item.opcode == OP_TICK)
			tick_n++;
	endtask

	initial begin
		req_t item;
		int   roll;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		send_idle = 9;
		recv_idle = 85;
		sent_n = 0;
		tick_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. A tick on an empty bank gives no report at all.
		send_request(tick_req());
		// Zero timeout: a one-shot is due at the very next tick, then freed.
		send_request(create_req(32'd0, 1'b0, 32'hFFFF_FFFF));
		send_request(tick_req());
		// A periodic timer with reload zero fires on every tick and stays in slot 0.
		send_request(create_req(32'd0, 1'b1, 32'h0000_0000));
		send_request(create_req(32'd1, 1'b0, 32'h5A5A_5A5A));
		// Largest timeout: this periodic timer is never reached during the run.
		send_request(create_req(32'hFFFF_FFFF, 1'b1, 32'h1234_5678));
		// Two due timers, reported newest first; the one-shot frees slot 1.
		send_request(tick_req());
		// Fill the remaining slots lowest first, the last one periodic with reload 3.
		for (int k = 0; k < 14; k++) begin
			if (k == 13)
				send_request(create_req(32'd3, 1'b1, $urandom));
			else
				send_request(create_req(32'd0, 1'b0, $urandom));
		end
		// The bank is full now, so this create is refused.
		send_request(create_req(32'd7, 1'b0, $urandom));
		// Fourteen timers fire at once, then only the periodic ones remain.
		send_request(tick_req());
		send_request(tick_req());
		permanent_made = 3;

		// Random part. Most creates are short one-shots so slots keep turning
		// over; a rationed few are periodic or carry a full 32-bit timeout.
		for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if ($urandom_range(0, 99) < 52) begin
				item = tick_req();
			end else begin
				item = create_req($urandom, 1'($urandom_range(0, 1)), $urandom);
				roll = $urandom_range(0, 99);
				if (roll < 6 && permanent_made < PERMANENT_BUDGET) begin
					permanent_made++;
					if (roll < 3) begin
						item.periodic = 1'b1;
						item.timeout_seconds = $urandom_range(0, 7);
					end
				end else begin
					item.periodic = 1'b0;
					item.timeout_seconds = (roll < 80) ? $urandom_range(0, 5)
						: $urandom_range(6, 40);
				end
			end
			send_request(item);
		end

		drain(SETTLE_CYCLES);
		$display("Sent %0d requests, %0d of them ticks, under three idle patterns in %0d cycles.",
			sent_n, tick_n, cycle_count);
		$display("Checked %0d create acknowledgements, %0d full refusals and %0d timer reports.",
			ack_count, full_count, fired_count);
		if (error_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (pending != 0)
				$error("%0d predicted reports never arrived", pending);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
